// File: src/hrat_pkg.sv
// Shared types and constants for the hot row activation tracker.
// No dependencies.
package hrat_pkg;

    // Stream payload widths
    localparam int IN_DATA_W  = 24;
    localparam int IN_USER_W  = 1;
    localparam int OUT_DATA_W = 48;
    localparam int OUT_CNT_W  = 20;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_SWAP_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ENTRIES_IN_USE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RESET_PERIOD   = 2'd2;

    // Bit-serial remainder unit
    localparam int MOD_W    = 32;
    localparam int MOD_CNT_W = 5;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_SCAN   = 5'b00010,
        S_DECIDE = 5'b00100,
        S_MOD    = 5'b01000,
        S_DONE   = 5'b10000
    } t_state;

endpackage

// File: src/hot_row_activation_tracker.sv
// Hot row activation tracker: per-bank frequent-row table with spillover counts.
// Depends on hrat_pkg.
//
// Channel   | Dir | Handshake                      | Content
// s_axis    | in  | s_axis_tvalid / s_axis_tready  | one controller clock: bank, row, activate
// m_axis    | out | m_axis_tvalid / m_axis_tready  | swap flag, tracked, counts, cleared
// cfg       | in  | i_cfg_valid / o_cfg_ready      | register index and write data
//
// An item searches n entries, n being the smaller of the bank's fill count and
// entries_in_use capped at ENTRIES, or none when activate is low or the bank is
// out of range, one per cycle through the entry memory's single read port. A row that
// ends up tracked with a nonzero threshold also runs the bit-serial remainder unit.
// A reset_period write recomputes the phase by the remainder unit; no item is taken.
// Reset (synchronous, active low) clears fill counts, spillover counts and control
// state at once; no clearing pass. Output register lets the next item start while
// a result waits.
module hot_row_activation_tracker #(
    parameter int BANKS      = 32,
    parameter int ENTRIES    = 64,
    parameter int ROW_BITS   = 16,
    parameter int COUNT_BITS = 20
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // [4:0] bank, [20:5] row, [23:21] zero
    input  logic [hrat_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // [0] activate
    input  logic [hrat_pkg::IN_USER_W-1:0]    s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [0] swap_needed, [1] row_tracked, [21:2] row_count, [41:22] spill_count,
    // [42] cleared, [47:43] zero
    output logic [hrat_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [hrat_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [hrat_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import hrat_pkg::*;

    localparam int BANK_W = (BANKS > 1) ? $clog2(BANKS) : 1;
    localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W  = $clog2(ENTRIES + 1);
    localparam int EW     = ROW_BITS + COUNT_BITS;
    localparam int AW     = BANK_W + IDX_W;
    localparam int DEPTH  = BANKS << IDX_W;

    // Configuration registers
    logic [19:0]              r_thr;
    logic [6:0]               r_eiu;
    logic [31:0]              r_period;
    logic                     r_prem_pend;

    // Clock count and phase within the reset period
    logic [31:0]              r_cyc;
    logic [31:0]              r_phase;

    // Per-bank state
    logic [CNT_W-1:0]         r_fill  [BANKS];
    logic [COUNT_BITS-1:0]    r_spill [BANKS];

    // Entry memory: {row, count}
    logic [EW-1:0]            r_mem [DEPTH];
    logic [EW-1:0]            r_rd;

    // Item in work
    t_state                   r_state;
    logic                     r_act;
    logic                     r_inb;
    logic [BANK_W-1:0]        r_bank;
    logic [ROW_BITS-1:0]      r_row;
    logic                     r_clr;
    logic [CNT_W-1:0]         r_ridx;
    logic [IDX_W-1:0]         r_cidx;
    logic                     r_pv;
    logic                     r_hit;
    logic [IDX_W-1:0]         r_hidx;
    logic [COUNT_BITS-1:0]    r_hcnt;
    logic                     r_vic;
    logic [IDX_W-1:0]         r_vidx;
    logic                     r_trk;
    logic [COUNT_BITS-1:0]    r_cnt;
    logic [COUNT_BITS-1:0]    r_spill_out;
    logic                     r_swap;

    // Remainder unit
    logic [MOD_W-1:0]         r_rem;
    logic [MOD_W-1:0]         r_dvd;
    logic [MOD_W-1:0]         r_dvs;
    logic [MOD_CNT_W-1:0]     r_mcnt;
    logic                     r_mod_prem;

    // Output register
    logic                     r_ovalid;
    logic [OUT_DATA_W-1:0]    r_odata;

    // Combinational
    logic [8:0]               bank9;
    logic [23:0]              row24;
    logic                     in_acc;
    logic [31:0]              n_cyc;
    logic [31:0]              n_phase;
    logic                     n_clr;
    logic [CNT_W-1:0]         cur_fill;
    logic [COUNT_BITS-1:0]    cur_spill;
    logic [8:0]               eiu9;
    logic [8:0]               lim9;
    logic [8:0]               fill9;
    logic                     full;
    logic [8:0]               n9;
    logic [CNT_W-1:0]         scan_n;
    logic                     issue;
    logic [AW-1:0]            raddr;
    logic [ROW_BITS-1:0]      rd_row;
    logic [COUNT_BITS-1:0]    rd_cnt;
    logic [COUNT_BITS-1:0]    hit_new;
    logic [COUNT_BITS-1:0]    spill_new;
    logic                     we;
    logic [AW-1:0]            waddr;
    logic [EW-1:0]            wdata;
    logic [COUNT_BITS-1:0]    dec_cnt;
    logic                     dec_trk;
    logic                     dec_spill_inc;
    logic                     dec_fill_inc;
    logic [MOD_W:0]           mod_t;
    logic [MOD_W:0]           mod_r;
    logic [31:0]              cnt32;
    logic [31:0]              spl32;

    assign bank9  = {4'b0, s_axis_tdata[4:0]};
    assign row24  = {8'b0, s_axis_tdata[20:5]};
    assign s_axis_tready = (r_state == S_IDLE) && !r_prem_pend;
    assign in_acc = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready = 1'b1;

    // Advance the clock count and the period phase
    always_comb begin
        n_cyc   = r_cyc + 32'd1;
        n_phase = r_phase + 32'd1;
        n_clr   = 1'b0;
        if (r_period != 32'd0) begin
            if (n_cyc == 32'd0 || n_phase == r_period) begin
                n_phase = 32'd0;
                n_clr   = 1'b1;
            end
        end
    end

    // Bank view and search length
    assign cur_fill  = r_inb ? r_fill[r_bank]  : '0;
    assign cur_spill = r_inb ? r_spill[r_bank] : '0;
    assign eiu9   = {2'b0, r_eiu};
    assign lim9   = (eiu9 > 9'(ENTRIES)) ? 9'(ENTRIES) : eiu9;
    assign fill9  = 9'(cur_fill);
    assign full   = fill9 >= lim9;
    assign n9     = full ? lim9 : fill9;
    assign scan_n = (r_act && r_inb) ? n9[CNT_W-1:0] : '0;
    assign issue  = r_ridx < scan_n;
    assign raddr  = {r_bank, r_ridx[IDX_W-1:0]};
    assign rd_row = r_rd[EW-1:COUNT_BITS];
    assign rd_cnt = r_rd[COUNT_BITS-1:0];

    assign hit_new   = (r_hcnt == '1) ? r_hcnt : r_hcnt + 1'b1;
    assign spill_new = (cur_spill == '1) ? cur_spill : cur_spill + 1'b1;

    // Pick hit, free entry, victim or spillover
    always_comb begin
        we            = 1'b0;
        waddr         = '0;
        wdata         = '0;
        dec_cnt       = '0;
        dec_trk       = 1'b0;
        dec_spill_inc = 1'b0;
        dec_fill_inc  = 1'b0;
        if (r_state == S_DECIDE && r_act && r_inb) begin
            if (r_hit) begin
                we      = 1'b1;
                waddr   = {r_bank, r_hidx};
                wdata   = {r_row, hit_new};
                dec_cnt = hit_new;
                dec_trk = 1'b1;
            end else if (!full) begin
                we           = 1'b1;
                waddr        = {r_bank, cur_fill[IDX_W-1:0]};
                wdata        = {r_row, COUNT_BITS'(1)};
                dec_cnt      = COUNT_BITS'(1);
                dec_trk      = 1'b1;
                dec_fill_inc = 1'b1;
            end else if (r_vic) begin
                we      = 1'b1;
                waddr   = {r_bank, r_vidx};
                wdata   = {r_row, spill_new};
                dec_cnt = spill_new;
                dec_trk = 1'b1;
            end else begin
                dec_spill_inc = 1'b1;
            end
        end
    end

    // One restoring remainder step
    assign mod_t = {r_rem, r_dvd[MOD_W-1]};
    assign mod_r = (mod_t >= {1'b0, r_dvs}) ? mod_t - {1'b0, r_dvs} : mod_t;

    assign cnt32 = 32'(r_cnt);
    assign spl32 = 32'(r_spill_out);

    // Entry memory, one write and one registered read
    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[waddr] <= wdata;
        end
        r_rd <= r_mem[raddr];
    end

    // Hold the payload of the item in work and of the result
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_act  <= s_axis_tuser[0];
            r_bank <= bank9[BANK_W-1:0];
            r_row  <= row24[ROW_BITS-1:0];
        end
        if (r_state == S_SCAN && r_pv) begin
            if (!r_hit && rd_row == r_row) begin
                r_hidx <= r_cidx;
                r_hcnt <= rd_cnt;
            end
            if (!r_vic && rd_cnt == cur_spill) begin
                r_vidx <= r_cidx;
            end
        end
        if (r_state == S_SCAN) begin
            r_cidx <= r_ridx[IDX_W-1:0];
        end
        if (r_state == S_DECIDE) begin
            r_cnt       <= dec_cnt;
            r_spill_out <= dec_spill_inc ? spill_new : cur_spill;
        end
        if (r_state == S_DONE && (!r_ovalid || m_axis_tready)) begin
            r_odata <= {5'b0, r_clr, spl32[OUT_CNT_W-1:0], cnt32[OUT_CNT_W-1:0],
                        r_trk, r_swap};
        end
    end

    // Control: sequencer, per-bank counts, configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_thr       <= 20'd512;
            r_eiu       <= 7'd64;
            r_period    <= 32'd32000000;
            r_prem_pend <= 1'b0;
            r_cyc       <= '0;
            r_phase     <= '0;
            r_ovalid    <= 1'b0;
            r_inb       <= 1'b0;
            r_clr       <= 1'b0;
            r_ridx      <= '0;
            r_pv        <= 1'b0;
            r_hit       <= 1'b0;
            r_vic       <= 1'b0;
            r_trk       <= 1'b0;
            r_swap      <= 1'b0;
            r_rem       <= '0;
            r_dvd       <= '0;
            r_dvs       <= '0;
            r_mcnt      <= '0;
            r_mod_prem  <= 1'b0;
            for (int b = 0; b < BANKS; b++) begin
                r_fill[b]  <= '0;
                r_spill[b] <= '0;
            end
        end else begin
            // Drop the result once taken
            if (m_axis_tvalid && m_axis_tready) begin
                r_ovalid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (r_prem_pend) begin
                        r_rem       <= '0;
                        r_dvd       <= r_cyc;
                        r_dvs       <= r_period;
                        r_mcnt      <= '0;
                        r_mod_prem  <= 1'b1;
                        r_prem_pend <= 1'b0;
                        r_state     <= S_MOD;
                    end else if (s_axis_tvalid) begin
                        r_cyc   <= n_cyc;
                        r_phase <= n_phase;
                        r_clr   <= n_clr;
                        if (n_clr) begin
                            for (int b = 0; b < BANKS; b++) begin
                                r_fill[b]  <= '0;
                                r_spill[b] <= '0;
                            end
                        end
                        r_inb   <= bank9 < 9'(BANKS);
                        r_ridx  <= '0;
                        r_pv    <= 1'b0;
                        r_hit   <= 1'b0;
                        r_vic   <= 1'b0;
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    // Issue one read and check the entry read last cycle
                    r_pv <= issue;
                    if (issue) begin
                        r_ridx <= r_ridx + 1'b1;
                    end
                    if (r_pv) begin
                        if (rd_row == r_row) begin
                            r_hit <= 1'b1;
                        end
                        if (rd_cnt == cur_spill) begin
                            r_vic <= 1'b1;
                        end
                    end
                    if (!issue && !r_pv) begin
                        r_state <= S_DECIDE;
                    end
                end
                S_DECIDE: begin
                    if (dec_fill_inc) begin
                        r_fill[r_bank] <= cur_fill + 1'b1;
                    end
                    if (dec_spill_inc) begin
                        r_spill[r_bank] <= spill_new;
                    end
                    r_trk <= dec_trk;
                    if (dec_trk && r_thr != 20'd0) begin
                        r_rem      <= '0;
                        r_dvd      <= 32'(dec_cnt);
                        r_dvs      <= 32'(r_thr);
                        r_mcnt     <= '0;
                        r_mod_prem <= 1'b0;
                        r_state    <= S_MOD;
                    end else begin
                        r_swap  <= 1'b0;
                        r_state <= S_DONE;
                    end
                end
                S_MOD: begin
                    r_rem  <= mod_r[MOD_W-1:0];
                    r_dvd  <= {r_dvd[MOD_W-2:0], 1'b0};
                    r_mcnt <= r_mcnt + 1'b1;
                    if (r_mcnt == '1) begin
                        if (r_mod_prem) begin
                            r_phase <= mod_r[MOD_W-1:0];
                            r_state <= S_IDLE;
                        end else begin
                            r_swap  <= (mod_r[MOD_W-1:0] == '0);
                            r_state <= S_DONE;
                        end
                    end
                end
                S_DONE: begin
                    if (!r_ovalid || m_axis_tready) begin
                        r_ovalid <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase

            // Register writes
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    REG_SWAP_THRESHOLD: r_thr <= i_cfg_data[19:0];
                    REG_ENTRIES_IN_USE: r_eiu <= i_cfg_data[6:0];
                    REG_RESET_PERIOD: begin
                        r_period    <= i_cfg_data;
                        r_prem_pend <= 1'b1;
                    end
                    default: ;
                endcase
            end
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;

    // Checks
    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_ridx <= scan_n))
        else $error("scan index ran past search length");

    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) |-> $past(r_state == S_DONE))
        else $error("result raised outside done state");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DECIDE && r_inb) |-> (9'(cur_fill) <= 9'(ENTRIES)))
        else $error("fill count above table size");

    a_accept_starts_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> (r_state == S_SCAN))
        else $error("accepted item did not start a search");

endmodule

// File: verif/hot_row_activation_tracker_tb.sv
// Testbench for hot_row_activation_tracker: directed table then randomized phases, each item
// checked against its typed result or an in-bench hot row table predictor. Depends on hrat_pkg.
module hot_row_activation_tracker_tb;
    import hrat_pkg::*;

    localparam int NBANK   = 32;
    localparam int NENT    = 64;
    localparam int CMAX    = 20'hFFFFF;
    localparam int WDOG    = 5000;
    localparam int SETTLE  = 150;

    typedef struct packed {
        logic        swap;
        logic        tracked;
        logic [19:0] count;
        logic [19:0] spill;
        logic        cleared;
    } t_result;

    typedef enum logic {ROW_ITEM, ROW_CFG} t_kind;

    typedef struct {
        t_kind       kind;
        logic        act;
        logic [4:0]  bank;
        logic [15:0] row;
        logic [1:0]  idx;
        logic [31:0] data;
        bit          typed;
        t_result     res;
    } t_stim;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [IN_DATA_W-1:0] s_axis_tdata = '0;
    logic [IN_USER_W-1:0] s_axis_tuser = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    hot_row_activation_tracker dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Predictor state
    bit          pv_valid [NBANK][NENT];
    logic [15:0] pv_row   [NBANK][NENT];
    logic [19:0] pv_count [NBANK][NENT];
    logic [19:0] pv_spill [NBANK];
    logic [31:0] pv_cycle;
    logic [19:0] pv_thresh;
    logic [6:0]  pv_limit;
    logic [31:0] pv_period;

    t_result expected_q[$];
    int      errors = 0;
    bit      calm = 0;
    int      quiet = 0;

    function automatic logic [19:0] sat_inc(logic [19:0] v);
        return (v == CMAX) ? v : v + 20'd1;
    endfunction

    function automatic void clear_tables();
        for (int b = 0; b < NBANK; b++) begin
            pv_spill[b] = '0;
            for (int e = 0; e < NENT; e++) pv_valid[b][e] = 0;
        end
    endfunction

    // Append one expectation at the tail of the queue
    function automatic void expect_result(t_result r);
        expected_q.insert(expected_q.size(), r);
    endfunction

    // Advance the table by one controller clock and return its result
    function automatic t_result track_row(logic act, logic [4:0] bank, logic [15:0] row);
        t_result r;
        int lim, hit, freei, victim;
        r = '0;
        hit = -1; freei = -1; victim = -1;
        pv_cycle = pv_cycle + 32'd1;
        if (pv_period != 0 && (pv_cycle % pv_period) == 0) begin
            clear_tables();
            r.cleared = 1'b1;
        end
        lim = (pv_limit > NENT) ? NENT : pv_limit;
        if (act) begin
            for (int i = 0; i < lim; i++) begin
                if (pv_valid[bank][i]) begin
                    if (hit < 0 && pv_row[bank][i] == row) hit = i;
                    if (victim < 0 && pv_count[bank][i] == pv_spill[bank]) victim = i;
                end else if (freei < 0) begin
                    freei = i;
                end
            end
            if (hit >= 0) begin
                pv_count[bank][hit] = sat_inc(pv_count[bank][hit]);
                r.count = pv_count[bank][hit];
                r.tracked = 1'b1;
            end else if (freei >= 0) begin
                pv_valid[bank][freei] = 1;
                pv_row[bank][freei] = row;
                pv_count[bank][freei] = 20'd1;
                r.count = 20'd1;
                r.tracked = 1'b1;
            end else if (victim >= 0) begin
                pv_row[bank][victim] = row;
                pv_count[bank][victim] = sat_inc(pv_spill[bank]);
                r.count = pv_count[bank][victim];
                r.tracked = 1'b1;
            end else begin
                pv_spill[bank] = sat_inc(pv_spill[bank]);
            end
            if (r.tracked && pv_thresh != 0 && (r.count % pv_thresh) == 0) r.swap = 1'b1;
        end
        r.spill = pv_spill[bank];
        return r;
    endfunction

    // Send one item; hold it until accepted, with random idle before it unless calm
    task automatic send_item(logic act, logic [4:0] bank, logic [15:0] row,
                             bit typed, t_result res);
        t_result p;
        while (!calm && $urandom_range(0, 99) < 34) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'b000, row, bank};
        s_axis_tuser  <= act;
        do @(posedge i_clk); while (!s_axis_tready);
        p = track_row(act, bank, row);
        expect_result(typed ? res : p);
        // drop valid before the next drive
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Drain, let the block settle, then write one register
    task automatic write_reg(logic [1:0] idx, logic [31:0] data);
        wait (expected_q.size() == 0);
        repeat (SETTLE) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            REG_SWAP_THRESHOLD: pv_thresh = data[19:0];
            REG_ENTRIES_IN_USE: pv_limit  = data[6:0];
            REG_RESET_PERIOD:   pv_period = data;
            default: ;
        endcase
        // phase recompute after a period write takes no item
        repeat (40) @(posedge i_clk);
    endtask

    // Check each result against the oldest expectation
    always @(posedge i_clk) begin
        t_result got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.swap    = m_axis_tdata[0];
            got.tracked = m_axis_tdata[1];
            got.count   = m_axis_tdata[21:2];
            got.spill   = m_axis_tdata[41:22];
            got.cleared = m_axis_tdata[42];
            if (expected_q.size() == 0) begin
                $display("%0t unexpected item: actual %h", $time, got);
                errors++;
            end else begin
                want = expected_q.pop_front();
                if (got.swap !== want.swap) begin
                    $display("%0t swap_needed: expected %0d actual %0d", $time, want.swap, got.swap);
                    errors++;
                end
                if (got.tracked !== want.tracked) begin
                    $display("%0t row_tracked: expected %0d actual %0d", $time,
                             want.tracked, got.tracked);
                    errors++;
                end
                if (got.count !== want.count) begin
                    $display("%0t row_count: expected %0d actual %0d", $time,
                             want.count, got.count);
                    errors++;
                end
                if (got.spill !== want.spill) begin
                    $display("%0t spill_count: expected %0d actual %0d", $time,
                             want.spill, got.spill);
                    errors++;
                end
                if (got.cleared !== want.cleared) begin
                    $display("%0t cleared: expected %0d actual %0d", $time,
                             want.cleared, got.cleared);
                    errors++;
                end
            end
        end
        m_axis_tready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 34);
    end

    // Watchdog on cycles with no handshake at all
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (i_cfg_valid && o_cfg_ready) || !i_rst_n)
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= WDOG) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    t_stim directed [$];
    logic [31:0] phase_cfg [7][3] = '{
        '{32'd1,       32'd1,   32'd0},
        '{32'd3,       32'd2,   32'd13},
        '{32'd0,       32'd0,   32'd5},
        '{32'hFFFFF,   32'd127, 32'd1},
        '{32'd7,       32'd3,   32'hFFFFFFFF},
        '{32'd2,       32'd8,   32'd40},
        '{32'd512,     32'd64,  32'd32000000}
    };

    function automatic t_stim item(logic a, logic [4:0] b, logic [15:0] r);
        t_stim s;
        s = '{ROW_ITEM, a, b, r, 2'd0, 32'd0, 0, '0};
        return s;
    endfunction

    function automatic t_stim item_typed(logic a, logic [4:0] b, logic [15:0] r,
                                         t_result res);
        t_stim s;
        s = '{ROW_ITEM, a, b, r, 2'd0, 32'd0, 1, res};
        return s;
    endfunction

    function automatic t_stim reg_row(logic [1:0] idx, logic [31:0] d);
        t_stim s;
        s = '{ROW_CFG, 1'b0, 5'd0, 16'd0, idx, d, 0, '0};
        return s;
    endfunction

    // Append one row at the tail of the stimulus table
    function automatic void add_row(t_stim s);
        directed.insert(directed.size(), s);
    endfunction

    initial begin
        logic       act;
        logic [4:0] bank;
        logic [15:0] row;
        pv_thresh = 20'd512;
        pv_limit  = 7'd64;
        pv_period = 32'd32000000;
        pv_cycle  = '0;
        clear_tables();

        // Directed: reset values, extremes of fields, spillover miss and replace
        add_row(item_typed(1'b0, 5'd0,  16'h0000, '{0, 0, 0, 0, 0}));
        add_row(item_typed(1'b1, 5'd0,  16'h0000, '{0, 1, 1, 0, 0}));
        add_row(item_typed(1'b1, 5'd0,  16'h0000, '{0, 1, 2, 0, 0}));
        add_row(item_typed(1'b1, 5'd31, 16'hFFFF, '{0, 1, 1, 0, 0}));
        add_row(item_typed(1'b0, 5'd31, 16'hFFFF, '{0, 0, 0, 0, 0}));
        add_row(reg_row(REG_SWAP_THRESHOLD, 32'd1));
        add_row(reg_row(REG_ENTRIES_IN_USE, 32'd1));
        add_row(reg_row(REG_RESET_PERIOD, 32'd0));
        add_row(item(1'b1, 5'd1, 16'hAAAA));
        add_row(item(1'b1, 5'd1, 16'h5555));
        add_row(item(1'b1, 5'd1, 16'h5555));
        add_row(item(1'b1, 5'd1, 16'hAAAA));
        add_row(item(1'b0, 5'd1, 16'h1234));
        add_row(item(1'b1, 5'd0, 16'h0000));
        add_row(reg_row(REG_ENTRIES_IN_USE, 32'd0));
        add_row(item(1'b1, 5'd2, 16'h0001));
        add_row(item(1'b1, 5'd2, 16'h0001));
        add_row(reg_row(REG_SWAP_THRESHOLD, 32'd0));
        add_row(reg_row(REG_ENTRIES_IN_USE, 32'd127));
        add_row(reg_row(REG_RESET_PERIOD, 32'd3));
        add_row(item(1'b1, 5'd0, 16'h0000));
        add_row(item(1'b1, 5'd0, 16'h0000));
        add_row(item(1'b1, 5'd0, 16'h0000));

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[i]) begin
            if (directed[i].kind == ROW_CFG)
                write_reg(directed[i].idx, directed[i].data);
            else
                send_item(directed[i].act, directed[i].bank, directed[i].row,
                          directed[i].typed, directed[i].res);
        end

        // Random phases: mostly a few hot rows in a few banks, some noise
        for (int ph = 0; ph < 7; ph++) begin
            write_reg(REG_SWAP_THRESHOLD, phase_cfg[ph][0]);
            write_reg(REG_ENTRIES_IN_USE, phase_cfg[ph][1]);
            write_reg(REG_RESET_PERIOD, phase_cfg[ph][2]);
            calm = (ph == 1);
            for (int n = 0; n < 76; n++) begin
                act  = ($urandom_range(0, 7) != 0);
                bank = ($urandom_range(0, 9) == 0) ? 5'($urandom) : 5'($urandom_range(0, 2));
                row  = ($urandom_range(0, 9) == 0) ? 16'($urandom)
                                                   : 16'($urandom_range(0, 5) * 16'h1111);
                send_item(act, bank, row, 0, '0);
                // sender holds off until every result is back
                if (n == 40) wait (expected_q.size() == 0);
            end
            calm = 0;
        end

        wait (expected_q.size() == 0);
        repeat (SETTLE) @(posedge i_clk);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule

// File: hot_row_activation_tracker.f
src/hrat_pkg.sv
src/hot_row_activation_tracker.sv
verif/hot_row_activation_tracker_tb.sv
